// ===== rtl/core/mbcs_pkg.sv =====
// Shared types and constants of the Modbus TCP coil slave.
`default_nettype none
package mbcs_pkg;

  localparam int unsigned COIL_DEPTH_DEF     = 1024;
  localparam int unsigned MAX_READ_COILS_DEF = 256;
  localparam int unsigned QUEUE_DEPTH        = 2;
  localparam int unsigned INDEX_W            = 16;

  localparam logic [7:0]  SLAVE_ID_RST      = 8'd1;
  localparam logic [15:0] START_ADDRESS_RST = 16'd0;
  localparam logic [15:0] END_ADDRESS_RST   = 16'd1023;

  localparam logic [7:0] FC_READ_COILS  = 8'd1;
  localparam logic [7:0] FC_WRITE_COIL  = 8'd5;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_UNIT   = 3'd1,
    ST_RANGE  = 3'd2,
    ST_QTY    = 3'd3,
    ST_FUNC   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CFG_SLAVE_ID      = 2'd0,
    CFG_START_ADDRESS = 2'd1,
    CFG_END_ADDRESS   = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic [7:0]  slave_id;
    logic [15:0] start_address;
    logic [15:0] end_address;
  } mbcs_cfg_t;

  typedef struct packed {
    status_e            status;
    logic [INDEX_W-1:0] index;
    logic [15:0]        transaction_id;
    logic [15:0]        protocol_id;
    logic [15:0]        frame_length;
    logic [7:0]         unit_id;
    logic [7:0]         function_code;
    logic [15:0]        coil_address;
    logic [15:0]        request_word;
  } mbcs_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/modbus_tcp_coil_slave.sv =====
// Flow: an accepted request passes the front-end states check, quotient, remainder and
// push, or check and push if refused, and waits in push while the queue is full.
// Back end: status item 1 beat, write reply 12 beats, read reply 9 header beats plus
// one data beat per started group of eight coils, one coil store read per cycle.
// The front end takes a new request only when idle; the queue lets it run ahead of replies.
// Reset: control cleared at once; a clearing pass zeroes every store entry, replies wait.
`default_nettype none
module modbus_tcp_coil_slave #(
  parameter int unsigned COIL_DEPTH     = mbcs_pkg::COIL_DEPTH_DEF,
  parameter int unsigned MAX_READ_COILS = mbcs_pkg::MAX_READ_COILS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] transaction_id_i,
  input  logic [15:0] protocol_id_i,
  input  logic [15:0] frame_length_i,
  input  logic [7:0]  unit_id_i,
  input  logic [7:0]  function_code_i,
  input  logic [15:0] coil_address_i,
  input  logic [15:0] request_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  reply_byte_o,
  output logic [2:0]  status_o,
  output logic        last_o
);
  import mbcs_pkg::*;

  mbcs_cfg_t cfg_q;
  mbcs_cmd_t push_cmd, head_cmd;
  logic      q_push, q_full, q_pop, q_empty;
  status_e   back_status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slave_id      <= SLAVE_ID_RST;
      cfg_q.start_address <= START_ADDRESS_RST;
      cfg_q.end_address   <= END_ADDRESS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_SLAVE_ID:      cfg_q.slave_id      <= cfg_data_i[7:0];
        CFG_START_ADDRESS: cfg_q.start_address <= cfg_data_i;
        CFG_END_ADDRESS:   cfg_q.end_address   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mbcs_front #(
    .COIL_DEPTH     (COIL_DEPTH),
    .MAX_READ_COILS (MAX_READ_COILS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .transaction_id_i (transaction_id_i),
    .protocol_id_i    (protocol_id_i),
    .frame_length_i   (frame_length_i),
    .unit_id_i        (unit_id_i),
    .function_code_i  (function_code_i),
    .coil_address_i   (coil_address_i),
    .request_word_i   (request_word_i),
    .push_o           (q_push),
    .cmd_o            (push_cmd),
    .full_i           (q_full)
  );

  mbcs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (head_cmd)
  );

  mbcs_back #(
    .COIL_DEPTH     (COIL_DEPTH),
    .MAX_READ_COILS (MAX_READ_COILS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_cmd),
    .empty_i      (q_empty),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .reply_byte_o (reply_byte_o),
    .status_o     (back_status),
    .last_o       (last_o)
  );

  assign status_o = back_status;

  a_status_beat_form : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> reply_byte_o == 8'd0 && last_o)
    else $error("status beat carries data or is not last");

  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("front end pushed into a full queue");

  a_no_pop_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("back end popped an empty queue");

endmodule
`default_nettype wire

// ===== rtl/core/mbcs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mbcs_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/core/mbcs_front.sv =====
// Request front end: accept, classify and map the coil address onto the store.
`default_nettype none
module mbcs_front #(
  parameter int unsigned COIL_DEPTH     = mbcs_pkg::COIL_DEPTH_DEF,
  parameter int unsigned MAX_READ_COILS = mbcs_pkg::MAX_READ_COILS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mbcs_pkg::mbcs_cfg_t cfg_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [15:0]         transaction_id_i,
  input  logic [15:0]         protocol_id_i,
  input  logic [15:0]         frame_length_i,
  input  logic [7:0]          unit_id_i,
  input  logic [7:0]          function_code_i,
  input  logic [15:0]         coil_address_i,
  input  logic [15:0]         request_word_i,
  output logic                push_o,
  output mbcs_pkg::mbcs_cmd_t cmd_o,
  input  logic                full_i
);
  import mbcs_pkg::*;

  localparam logic [2:0] F_IDLE  = 3'd0;
  localparam logic [2:0] F_CHECK = 3'd1;
  localparam logic [2:0] F_QUOT  = 3'd2;
  localparam logic [2:0] F_REM   = 3'd3;
  localparam logic [2:0] F_PUSH  = 3'd4;

  // Reciprocal of the store depth, exact for every 16-bit offset.
  localparam int unsigned     RED_SHIFT = 16 + $clog2(COIL_DEPTH);
  localparam longint unsigned RED_MUL   =
    ((64'd1 << RED_SHIFT) + 64'(COIL_DEPTH) - 64'd1) / 64'(COIL_DEPTH);
  localparam logic [17:0]     RED_MUL_W = 18'(RED_MUL);

  logic [2:0]  state_q, state_d;
  mbcs_cmd_t   cmd_q, cmd_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] quot_q, quot_d;
  status_e     chk_status;
  logic [16:0] span_end;
  logic [33:0] quot_prod;
  logic [32:0] quot_back;

  assign span_end  = {1'b0, cmd_q.coil_address} + {1'b0, cmd_q.request_word};
  assign quot_prod = {18'd0, rem_q} * {16'd0, RED_MUL_W};
  assign quot_back = 33'(quot_q) * 33'(COIL_DEPTH);

  always_comb begin
    priority if (cmd_q.unit_id != cfg_i.slave_id) begin
      chk_status = ST_UNIT;
    end else if (cmd_q.function_code != FC_READ_COILS &&
                 cmd_q.function_code != FC_WRITE_COIL) begin
      chk_status = ST_FUNC;
    end else if (cmd_q.coil_address < cfg_i.start_address ||
                 cmd_q.coil_address > cfg_i.end_address) begin
      chk_status = ST_RANGE;
    end else if (cmd_q.function_code == FC_READ_COILS &&
                 (cmd_q.request_word == 16'd0 ||
                  cmd_q.request_word > 16'(MAX_READ_COILS))) begin
      chk_status = ST_QTY;
    end else if (cmd_q.function_code == FC_READ_COILS &&
                 span_end > ({1'b0, cfg_i.end_address} + 17'd1)) begin
      chk_status = ST_RANGE;
    end else begin
      chk_status = ST_OK;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    rem_d   = rem_q;
    quot_d  = quot_q;
    push_o  = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          cmd_d.status         = ST_OK;
          cmd_d.index          = '0;
          cmd_d.transaction_id = transaction_id_i;
          cmd_d.protocol_id    = protocol_id_i;
          cmd_d.frame_length   = frame_length_i;
          cmd_d.unit_id        = unit_id_i;
          cmd_d.function_code  = function_code_i;
          cmd_d.coil_address   = coil_address_i;
          cmd_d.request_word   = request_word_i;
          state_d              = F_CHECK;
        end
      end
      F_CHECK: begin
        cmd_d.status = chk_status;
        rem_d        = cmd_q.coil_address - cfg_i.start_address;
        state_d      = (chk_status == ST_OK) ? F_QUOT : F_PUSH;
      end
      F_QUOT: begin
        quot_d  = 16'(quot_prod >> RED_SHIFT);
        state_d = F_REM;
      end
      F_REM: begin
        rem_d   = rem_q - quot_back[15:0];
        state_d = F_PUSH;
      end
      F_PUSH: begin
        cmd_d.index = INDEX_W'(rem_q);
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign in_stall_o = (state_q != F_IDLE);

  always_comb begin
    cmd_o       = cmd_q;
    cmd_o.index = INDEX_W'(rem_q);
  end

endmodule
`default_nettype wire

// ===== rtl/core/mbcs_queue.sv =====
// Short command queue between front end and back end.
`default_nettype none
module mbcs_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mbcs_pkg::mbcs_cmd_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output mbcs_pkg::mbcs_cmd_t head_o
);
  import mbcs_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  mbcs_cmd_t        mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mbcs_back.sv =====
// Back end: coil store, clearing pass and reply byte sequencer.
`default_nettype none
module mbcs_back #(
  parameter int unsigned COIL_DEPTH     = mbcs_pkg::COIL_DEPTH_DEF,
  parameter int unsigned MAX_READ_COILS = mbcs_pkg::MAX_READ_COILS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mbcs_pkg::mbcs_cmd_t head_i,
  input  logic                empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          reply_byte_o,
  output mbcs_pkg::status_e   status_o,
  output logic                last_o
);
  import mbcs_pkg::*;

  localparam int unsigned IDX_W = $clog2(COIL_DEPTH);
  localparam int unsigned QTY_W = $clog2(MAX_READ_COILS + 1);
  localparam logic [7:0]  LEN_BASE = 8'd3;

  localparam logic [2:0] B_CLEAR  = 3'd0;
  localparam logic [2:0] B_IDLE   = 3'd1;
  localparam logic [2:0] B_STAT   = 3'd2;
  localparam logic [2:0] B_HDR    = 3'd3;
  localparam logic [2:0] B_GATHER = 3'd4;
  localparam logic [2:0] B_DATA   = 3'd5;

  function automatic logic [7:0] hdr_byte(input mbcs_cmd_t c, input logic [3:0] i,
                                          input logic [7:0] n);
    logic       wr;
    logic [7:0] b;
    wr = (c.function_code == FC_WRITE_COIL);
    unique case (i)
      4'd0:    b = c.transaction_id[15:8];
      4'd1:    b = c.transaction_id[7:0];
      4'd2:    b = c.protocol_id[15:8];
      4'd3:    b = c.protocol_id[7:0];
      4'd4:    b = wr ? c.frame_length[15:8] : 8'd0;
      4'd5:    b = wr ? c.frame_length[7:0] : LEN_BASE + n;
      4'd6:    b = c.unit_id;
      4'd7:    b = wr ? FC_WRITE_COIL : FC_READ_COILS;
      4'd8:    b = wr ? c.coil_address[15:8] : n;
      4'd9:    b = c.coil_address[7:0];
      4'd10:   b = c.request_word[15:8];
      4'd11:   b = c.request_word[7:0];
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  logic [2:0]       state_q, state_d;
  mbcs_cmd_t        cmd_q, cmd_d;
  logic [3:0]       idx_q, idx_d;
  logic [QTY_W-1:0] rem_q, rem_d;
  logic [3:0]       issued_q, issued_d, got_q, got_d;
  logic [7:0]       byte_q, byte_d;
  logic [IDX_W-1:0] ptr_q, ptr_d, clr_q, clr_d;
  logic             pend_q;
  logic             out_vld_q, out_vld_d;
  logic [7:0]       out_byte_q, out_byte_d;
  status_e          out_stat_q, out_stat_d;
  logic             out_last_q, out_last_d;

  logic             ld, emit, e_last;
  logic [7:0]       e_byte;
  status_e          e_stat;
  logic [3:0]       nb;
  logic [7:0]       nbytes;
  logic             we, re, wdata, rdata;
  logic [IDX_W-1:0] waddr;

  assign ld     = !out_vld_q || !out_stall_i;
  assign nb     = (rem_q >= QTY_W'(8)) ? 4'd8 : 4'(rem_q);
  assign nbytes = 8'((17'(cmd_q.request_word) + 17'd7) >> 3);

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    idx_d    = idx_q;
    rem_d    = rem_q;
    issued_d = issued_q;
    got_d    = got_q;
    byte_d   = byte_q;
    ptr_d    = ptr_q;
    clr_d    = clr_q;
    pop_o    = 1'b0;
    we       = 1'b0;
    waddr    = clr_q;
    wdata    = 1'b0;
    re       = 1'b0;
    emit     = 1'b0;
    e_byte   = 8'd0;
    e_stat   = ST_OK;
    e_last   = 1'b0;
    if (pend_q) begin
      byte_d[got_q[2:0]] = rdata;
      got_d              = got_q + 4'd1;
    end
    unique case (state_q)
      B_CLEAR: begin
        we    = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == IDX_W'(COIL_DEPTH - 1)) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!empty_i) begin
          pop_o    = 1'b1;
          cmd_d    = head_i;
          idx_d    = 4'd0;
          issued_d = 4'd0;
          got_d    = 4'd0;
          byte_d   = 8'd0;
          rem_d    = QTY_W'(head_i.request_word);
          ptr_d    = IDX_W'(head_i.index);
          if (head_i.status != ST_OK) begin
            state_d = B_STAT;
          end else begin
            if (head_i.function_code == FC_WRITE_COIL) begin
              we    = 1'b1;
              waddr = IDX_W'(head_i.index);
              wdata = |head_i.request_word[15:8];
            end
            state_d = B_HDR;
          end
        end
      end
      B_STAT: begin
        if (ld) begin
          emit    = 1'b1;
          e_stat  = cmd_q.status;
          e_last  = 1'b1;
          state_d = B_IDLE;
        end
      end
      B_HDR: begin
        if (ld) begin
          emit   = 1'b1;
          e_byte = hdr_byte(cmd_q, idx_q, nbytes);
          idx_d  = idx_q + 4'd1;
          if (cmd_q.function_code == FC_WRITE_COIL) begin
            if (idx_q == 4'd11) begin
              e_last  = 1'b1;
              state_d = B_IDLE;
            end
          end else if (idx_q == 4'd8) begin
            state_d = B_GATHER;
          end
        end
      end
      B_GATHER: begin
        if (issued_q < nb) begin
          re       = 1'b1;
          issued_d = issued_q + 4'd1;
          ptr_d    = (ptr_q == IDX_W'(COIL_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
        end
        if (got_q == nb) begin
          state_d = B_DATA;
        end
      end
      B_DATA: begin
        if (ld) begin
          emit     = 1'b1;
          e_byte   = byte_q;
          e_last   = (rem_q <= QTY_W'(8));
          rem_d    = rem_q - QTY_W'(nb);
          issued_d = 4'd0;
          got_d    = 4'd0;
          byte_d   = 8'd0;
          state_d  = e_last ? B_IDLE : B_GATHER;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d  = out_vld_q && out_stall_i;
    out_byte_d = out_byte_q;
    out_stat_d = out_stat_q;
    out_last_d = out_last_q;
    if (ld && emit) begin
      out_vld_d  = 1'b1;
      out_byte_d = e_byte;
      out_stat_d = e_stat;
      out_last_d = e_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_CLEAR;
      clr_q     <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      pend_q    <= re;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    idx_q      <= idx_d;
    rem_q      <= rem_d;
    issued_q   <= issued_d;
    got_q      <= got_d;
    byte_q     <= byte_d;
    ptr_q      <= ptr_d;
    out_byte_q <= out_byte_d;
    out_stat_q <= out_stat_d;
    out_last_q <= out_last_d;
  end

  mbcs_ram #(
    .WIDTH (1),
    .DEPTH (COIL_DEPTH)
  ) u_coil_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (ptr_q),
    .rdata_o (rdata)
  );

  assign out_valid_o  = out_vld_q;
  assign reply_byte_o = out_byte_q;
  assign status_o     = out_stat_q;
  assign last_o       = out_last_q;

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the Modbus TCP coil slave: read coils and write single coil.
`timescale 1ns / 100ps

module tb;
  import mbcs_pkg::*;

  localparam int unsigned STORE_DEPTH    = COIL_DEPTH_DEF;
  localparam int unsigned MAX_COILS      = MAX_READ_COILS_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 6000;
  localparam int unsigned DRAIN_CYCLES   = 60;

  typedef struct packed {
    logic [15:0] transaction_id;
    logic [15:0] protocol_id;
    logic [15:0] frame_length;
    logic [7:0]  unit_id;
    logic [7:0]  function_code;
    logic [15:0] coil_address;
    logic [15:0] request_word;
  } request_t;

  typedef struct packed {
    logic [7:0] data;
    status_e    status;
    logic       last;
  } reply_beat_t;

  class coil_scoreboard;
    bit          coils [STORE_DEPTH];
    logic [7:0]  slave_id;
    logic [15:0] start_addr;
    logic [15:0] end_addr;
    reply_beat_t reply_q [$];
    int          errors;
    int          beats_checked;
    int          requests_seen;
    int          status_seen [5];

    function new();
      foreach (coils[i]) coils[i] = 1'b0;
      slave_id   = SLAVE_ID_RST;
      start_addr = START_ADDRESS_RST;
      end_addr   = END_ADDRESS_RST;
    endfunction

    function void set_register(cfg_index_e idx, logic [15:0] value);
      case (idx)
        CFG_SLAVE_ID:      slave_id   = value[7:0];
        CFG_START_ADDRESS: start_addr = value;
        CFG_END_ADDRESS:   end_addr   = value;
        default: ;
      endcase
    endfunction

    function void push_byte(logic [7:0] value, logic last);
      reply_beat_t b;
      b.data   = value;
      b.status = ST_OK;
      b.last   = last;
      reply_q  = {reply_q, b};
    endfunction

    function void push_status(status_e st);
      reply_beat_t b;
      b.data   = 8'h00;
      b.status = st;
      b.last   = 1'b1;
      reply_q  = {reply_q, b};
      status_seen[st]++;
    endfunction

    function void note_request(request_t r);
      int unsigned qty;
      int unsigned nbytes;
      int unsigned offset;
      int unsigned c;
      logic [7:0]  b;
      requests_seen++;
      if (r.unit_id != slave_id) begin
        push_status(ST_UNIT);
        return;
      end
      if (r.function_code != FC_READ_COILS && r.function_code != FC_WRITE_COIL) begin
        push_status(ST_FUNC);
        return;
      end
      if (r.coil_address < start_addr || r.coil_address > end_addr) begin
        push_status(ST_RANGE);
        return;
      end
      offset = 32'(r.coil_address) - 32'(start_addr);
      if (r.function_code == FC_READ_COILS) begin
        qty = r.request_word;
        if (qty == 0 || qty > MAX_COILS) begin
          push_status(ST_QTY);
          return;
        end
        if (32'(r.coil_address) + qty - 1 > 32'(end_addr)) begin
          push_status(ST_RANGE);
          return;
        end
        nbytes = (qty + 7) / 8;
        push_byte(r.transaction_id[15:8], 1'b0);
        push_byte(r.transaction_id[7:0], 1'b0);
        push_byte(r.protocol_id[15:8], 1'b0);
        push_byte(r.protocol_id[7:0], 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'(3 + nbytes), 1'b0);
        push_byte(r.unit_id, 1'b0);
        push_byte(FC_READ_COILS, 1'b0);
        push_byte(8'(nbytes), 1'b0);
        for (int unsigned i = 0; i < nbytes; i++) begin
          b = 8'h00;
          for (int unsigned j = 0; j < 8; j++) begin
            c = i * 8 + j;
            if (c < qty && coils[(offset + c) % STORE_DEPTH]) b[j] = 1'b1;
          end
          push_byte(b, i == nbytes - 1);
        end
      end else begin
        coils[offset % STORE_DEPTH] = (r.request_word[15:8] != 8'h00);
        push_byte(r.transaction_id[15:8], 1'b0);
        push_byte(r.transaction_id[7:0], 1'b0);
        push_byte(r.protocol_id[15:8], 1'b0);
        push_byte(r.protocol_id[7:0], 1'b0);
        push_byte(r.frame_length[15:8], 1'b0);
        push_byte(r.frame_length[7:0], 1'b0);
        push_byte(r.unit_id, 1'b0);
        push_byte(FC_WRITE_COIL, 1'b0);
        push_byte(r.coil_address[15:8], 1'b0);
        push_byte(r.coil_address[7:0], 1'b0);
        push_byte(r.request_word[15:8], 1'b0);
        push_byte(r.request_word[7:0], 1'b1);
      end
      status_seen[ST_OK]++;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function void check_beat(logic [7:0] data, logic [2:0] st, logic last);
      reply_beat_t want;
      beats_checked++;
      if (reply_q.size() == 0) begin
        flag($sformatf("unexpected beat: byte %02h status %0d last %0b", data, st, last));
        return;
      end
      want = reply_q.pop_front();
      if (data !== want.data || st !== want.status || last !== want.last)
        flag($sformatf({"beat mismatch: expected byte %02h status %0d last %0b, ",
                        "got byte %02h status %0d last %0b"},
                       want.data, want.status, want.last, data, st, last));
    endfunction

    function int pending();
      return reply_q.size();
    endfunction

    function void close_out();
      if (reply_q.size() != 0)
        flag($sformatf("%0d expected beats never arrived", reply_q.size()));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [15:0] transaction_id_i;
  logic [15:0] protocol_id_i;
  logic [15:0] frame_length_i;
  logic [7:0]  unit_id_i;
  logic [7:0]  function_code_i;
  logic [15:0] coil_address_i;
  logic [15:0] request_word_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  reply_byte_o;
  logic [2:0]  status_o;
  logic        last_o;

  coil_scoreboard sb;
  logic [7:0]     cur_slave;
  logic [15:0]    cur_start;
  logic [15:0]    cur_end;
  bit             no_idle;
  int unsigned    idle_cycles;
  int             settings_used;

  modbus_tcp_coil_slave dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .transaction_id_i (transaction_id_i),
    .protocol_id_i    (protocol_id_i),
    .frame_length_i   (frame_length_i),
    .unit_id_i        (unit_id_i),
    .function_code_i  (function_code_i),
    .coil_address_i   (coil_address_i),
    .request_word_i   (request_word_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .reply_byte_o     (reply_byte_o),
    .status_o         (status_o),
    .last_o           (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver side: hold stall high or low for random stretches, low while no_idle is set.
  initial begin
    int unsigned hold;
    bit          stall;
    hold        = 0;
    stall       = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold == 0) begin
        if (no_idle) begin
          stall = 1'b0;
          hold  = 1;
        end else begin
          stall = ($urandom_range(0, 99) < 30);
          hold  = pick_len();
        end
      end
      out_stall_i <= stall;
      hold--;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o)
        sb.set_register(cfg_index_e'(cfg_index_i), cfg_data_i);
      if (in_valid_i && !in_stall_o)
        sb.note_request({transaction_id_i, protocol_id_i, frame_length_i, unit_id_i,
                         function_code_i, coil_address_i, request_word_i});
      if (out_valid_o && !out_stall_i)
        sb.check_beat(reply_byte_o, status_o, last_o);
      if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && !in_stall_o) ||
          (out_valid_o && !out_stall_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no beat for %0d cycles, %0d beats still expected",
                 idle_cycles, sb.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_index_e idx, logic [15:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(logic [7:0] sid, logic [15:0] lo, logic [15:0] hi);
    cur_slave = sid;
    cur_start = lo;
    cur_end   = hi;
    write_reg(CFG_SLAVE_ID, {8'($urandom), sid});
    write_reg(CFG_START_ADDRESS, lo);
    write_reg(CFG_END_ADDRESS, hi);
    settings_used++;
  endtask

  task automatic send_request(request_t r);
    int unsigned gap;
    gap = 0;
    if (!no_idle && $urandom_range(0, 99) >= 40) gap = pick_len();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    transaction_id_i <= r.transaction_id;
    protocol_id_i    <= r.protocol_id;
    frame_length_i   <= r.frame_length;
    unit_id_i        <= r.unit_id;
    function_code_i  <= r.function_code;
    coil_address_i   <= r.coil_address;
    request_word_i   <= r.request_word;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic request_t make_req(logic [7:0] unit, logic [7:0] fc,
                                        logic [15:0] addr, logic [15:0] word);
    request_t r;
    r.transaction_id = 16'($urandom);
    r.protocol_id    = 16'($urandom);
    r.frame_length   = 16'($urandom);
    r.unit_id        = unit;
    r.function_code  = fc;
    r.coil_address   = addr;
    r.request_word   = word;
    return r;
  endfunction

  function automatic logic [15:0] pick_address();
    int unsigned lo;
    int unsigned hi;
    int unsigned r;
    lo = cur_start;
    hi = cur_end;
    r  = $urandom_range(0, 99);
    if (lo > hi || r >= 90) return 16'($urandom);
    if (r < 50 && hi - lo > 63) hi = lo + 63;
    return 16'($urandom_range(lo, hi));
  endfunction

  function automatic logic [15:0] pick_quantity();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(1, 24));
    if (r < 92) return 16'($urandom_range(25, 64));
    return 16'($urandom_range(65, MAX_COILS));
  endfunction

  function automatic request_t random_request();
    request_t    r;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    r   = make_req(cur_slave, FC_READ_COILS, pick_address(), 16'h0000);
    if (sel < 45) begin
      r.request_word = pick_quantity();
      if ($urandom_range(0, 9) == 0) r.coil_address = cur_end - 16'($urandom_range(0, 30));
    end else if (sel < 85) begin
      r.function_code = FC_WRITE_COIL;
      case ($urandom_range(0, 3))
        0:       r.request_word = 16'hFF00;
        1:       r.request_word = 16'h0000;
        default: r.request_word = 16'($urandom);
      endcase
    end else begin
      r.function_code = ($urandom_range(0, 1) != 0) ? FC_READ_COILS : FC_WRITE_COIL;
      r.request_word  = 16'($urandom);
      case (sel % 4)
        0:       r.unit_id       = 8'($urandom);
        1:       r.function_code = 8'($urandom);
        2:       r.coil_address  = 16'($urandom);
        default: r.request_word  = ($urandom_range(0, 1) != 0) ? 16'h0000 :
                                   16'($urandom_range(MAX_COILS + 1, 65535));
      endcase
    end
    return r;
  endfunction

  task automatic random_burst(int n);
    for (int k = 0; k < n; k++) begin
      no_idle = (k < n / 5);
      send_request(random_request());
    end
    no_idle = 1'b0;
    wait_idle();
  endtask

  initial begin
    request_t r;
    sb               = new();
    settings_used    = 0;
    no_idle          = 1'b0;
    idle_cycles      = 0;
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = CFG_SLAVE_ID;
    cfg_data_i       = 16'h0000;
    in_valid_i       = 1'b0;
    transaction_id_i = 16'h0000;
    protocol_id_i    = 16'h0000;
    frame_length_i   = 16'h0000;
    unit_id_i        = 8'h00;
    function_code_i  = 8'h00;
    coil_address_i   = 16'h0000;
    request_word_i   = 16'h0000;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    set_config(8'd1, 16'd0, 16'd1023);
    r = make_req(8'd1, FC_WRITE_COIL, 16'd0, 16'hFF00);
    r.transaction_id = 16'hFFFF;
    r.protocol_id    = 16'hFFFF;
    r.frame_length   = 16'hFFFF;
    send_request(r);
    r = make_req(8'd1, FC_WRITE_COIL, 16'd1023, 16'h0100);
    r.transaction_id = 16'h0000;
    r.protocol_id    = 16'h0000;
    r.frame_length   = 16'h0000;
    send_request(r);
    send_request(make_req(8'd1, FC_WRITE_COIL, 16'd7, 16'h00FF));
    send_request(make_req(8'd1, FC_WRITE_COIL, 16'd3, 16'h8000));
    send_request(make_req(8'd1, FC_READ_COILS, 16'd0, 16'd1));
    send_request(make_req(8'd1, FC_READ_COILS, 16'd0, 16'd8));
    send_request(make_req(8'd1, FC_READ_COILS, 16'd0, 16'd9));
    send_request(make_req(8'd1, FC_READ_COILS, 16'd768, 16'd256));
    send_request(make_req(8'd1, FC_READ_COILS, 16'd1016, 16'd8));
    send_request(make_req(8'd1, FC_READ_COILS, 16'd1000, 16'd25));
    send_request(make_req(8'd1, FC_READ_COILS, 16'd0, 16'd0));
    send_request(make_req(8'd1, FC_READ_COILS, 16'd0, 16'd257));
    send_request(make_req(8'd1, FC_READ_COILS, 16'd0, 16'hFFFF));
    send_request(make_req(8'd1, FC_READ_COILS, 16'd1024, 16'd0));
    send_request(make_req(8'd1, FC_WRITE_COIL, 16'd1024, 16'hFF00));
    send_request(make_req(8'd1, FC_WRITE_COIL, 16'hFFFF, 16'hFF00));
    send_request(make_req(8'd2, FC_READ_COILS, 16'd0, 16'd1));
    send_request(make_req(8'd2, 8'd3, 16'd0, 16'd1));
    send_request(make_req(8'd1, 8'd0, 16'd0, 16'd1));
    send_request(make_req(8'd1, 8'hFF, 16'd0, 16'd1));
    send_request(make_req(8'd1, 8'd3, 16'hFFFF, 16'd1));
    send_request(make_req(8'd1, FC_WRITE_COIL, 16'd0, 16'h0000));
    send_request(make_req(8'd1, FC_READ_COILS, 16'd0, 16'd16));
    random_burst(120);

    set_config(8'hA5, 16'd100, 16'd1123);
    random_burst(80);

    // Range wider than the store: aliased addresses share entries.
    set_config(8'h00, 16'd0, 16'hFFFF);
    send_request(make_req(8'h00, FC_WRITE_COIL, 16'd1029, 16'hFF00));
    send_request(make_req(8'h00, FC_READ_COILS, 16'd5, 16'd3));
    send_request(make_req(8'h00, FC_WRITE_COIL, 16'hFFFF, 16'h0100));
    send_request(make_req(8'h00, FC_READ_COILS, 16'd1023, 16'd1));
    random_burst(90);

    set_config(8'hFF, 16'hFF00, 16'hFFFF);
    random_burst(70);

    set_config(8'h5A, 16'd600, 16'd20);
    random_burst(30);

    set_config(8'd1, 16'd300, 16'd300);
    random_burst(50);

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    sb.close_out();

    $display("Ran %0d requests over %0d register settings, %0d reply beats checked.",
             sb.requests_seen, settings_used, sb.beats_checked);
    $display({"Outcomes: ok %0d, wrong unit %0d, out of range %0d, ",
              "bad quantity %0d, unsupported %0d"},
             sb.status_seen[ST_OK], sb.status_seen[ST_UNIT], sb.status_seen[ST_RANGE],
             sb.status_seen[ST_QTY], sb.status_seen[ST_FUNC]);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d failures", sb.errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== modbus_tcp_coil_slave.f =====
rtl/core/mbcs_pkg.sv
rtl/core/mbcs_ram.sv
rtl/core/mbcs_front.sv
rtl/core/mbcs_queue.sv
rtl/core/mbcs_back.sv
rtl/core/modbus_tcp_coil_slave.sv
test/tb.sv
